// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the glyph lookup engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)

`endif

// File: hdl/gle_pkg.sv
// Package with sizes, codes and control types of the glyph lookup engine.
`default_nettype none

package gle_pkg;

    localparam int MAX_GLYPHS = 256;
    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 8;

    localparam int GLYPH_IDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
    localparam int GLYPH_CNT_W = $clog2(MAX_GLYPHS + 1);
    localparam int ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int BMP_DEPTH   = MAX_GLYPHS * MAX_ROWS;
    localparam int BMP_ADDR_W  = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;

    localparam int OPCODE_W    = 2;
    localparam int ENTRY_W     = 13;
    localparam int CODE_W      = 32;
    localparam int WORD_W      = 64;
    localparam int ROWNUM_W    = 5;
    localparam int ROW_CFG_W   = 6;
    localparam int COL_CFG_W   = 4;
    localparam int GLYPH_CFG_W = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int WORD_BYTES  = WORD_W / 8;

    localparam logic [ROW_CFG_W-1:0]   ROW_COUNT_RST   = ROW_CFG_W'(16);
    localparam logic [COL_CFG_W-1:0]   COL_COUNT_RST   = COL_CFG_W'(8);
    localparam logic [GLYPH_CFG_W-1:0] GLYPH_COUNT_RST = '0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_WR_CODE = 2'd0,
        OP_WR_ROW  = 2'd1,
        OP_LOOKUP  = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT   = 2'd0,
        CFG_COL_COUNT   = 2'd1,
        CFG_GLYPH_COUNT = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_MISS,
        ST_ROW_READ,
        ST_ROW_LOAD
    } gle_state_t;

    typedef struct packed {
        logic wr_code;
        logic wr_row;
        logic start;
        logic probe;
        logic compare;
        logic row_read;
        logic load_row;
        logic load_miss;
    } gle_cmd_t;

    typedef struct packed {
        logic bounds_empty;
        logic hit;
        logic row_last;
        logic out_free;
    } gle_status_t;

endpackage

`default_nettype wire

// File: hdl/gle_ctrl.sv
// Controller state machine: sequences load, search, row and miss emission.
`default_nettype none

module gle_ctrl
    import gle_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [OPCODE_W-1:0] opcode,
    input  wire gle_status_t         status,
    output gle_cmd_t                 cmd
);

    gle_state_t state_reg;
    gle_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_WR_CODE: cmd.wr_code = 1'b1;
                        OP_WR_ROW:  cmd.wr_row  = 1'b1;
                        OP_LOOKUP:
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_PROBE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROBE:
            begin
                if (status.bounds_empty)
                begin
                    state_next = ST_MISS;
                end
                else
                begin
                    cmd.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = status.hit ? ST_ROW_READ : ST_PROBE;
            end
            ST_MISS:
            begin
                if (status.out_free)
                begin
                    cmd.load_miss = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_ROW_READ:
            begin
                cmd.row_read = 1'b1;
                state_next   = ST_ROW_LOAD;
            end
            ST_ROW_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.load_row = 1'b1;
                    state_next   = status.row_last ? ST_IDLE : ST_ROW_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/gle_datapath.sv
// Datapath: configuration, code table, bitmap store, search bounds and output register.
`default_nettype none

module gle_datapath
    import gle_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [ENTRY_W-1:0]     entry_index,
    input  wire logic signed [CODE_W-1:0] code_value,
    input  wire logic [WORD_W-1:0]      row_word,
    input  wire gle_cmd_t               cmd,
    output gle_status_t                 status,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [WORD_W-1:0]           row_pixels,
    output logic [ROWNUM_W-1:0]         row_number,
    output logic                        found,
    output logic                        last_row
);

    logic [ROW_CFG_W-1:0]   row_count_reg;
    logic [COL_CFG_W-1:0]   col_count_reg;
    logic [GLYPH_CFG_W-1:0] glyph_count_reg;

    logic signed [CODE_W-1:0] code_mem [MAX_GLYPHS];
    logic [WORD_W-1:0]        bitmap_mem [BMP_DEPTH];

    logic signed [CODE_W-1:0] key_reg;
    logic signed [CODE_W-1:0] code_rd_reg;
    logic [WORD_W-1:0]        bmp_rd_reg;
    logic [GLYPH_CNT_W-1:0]   low_reg;
    logic [GLYPH_CNT_W-1:0]   high_reg;
    logic [GLYPH_IDX_W-1:0]   mid_reg;
    logic [ROW_IDX_W-1:0]     row_reg;

    logic                     out_valid_reg;
    logic [WORD_W-1:0]        pixels_reg;
    logic [ROWNUM_W-1:0]      row_number_reg;
    logic                     found_reg;
    logic                     last_reg;

    logic [GLYPH_CNT_W-1:0]   glyph_limit;
    logic [ROW_CNT_W-1:0]     rows_eff;
    logic [COL_CFG_W-1:0]     cols_eff;
    logic [GLYPH_CNT_W:0]     bound_sum;
    logic [GLYPH_IDX_W-1:0]   mid_next;
    logic [BMP_ADDR_W-1:0]    bmp_rd_addr;
    logic [WORD_W-1:0]        byte_mask;
    logic                     key_below;

    // Configuration registers, stored as written and saturated where used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= ROW_COUNT_RST;
            col_count_reg   <= COL_COUNT_RST;
            glyph_count_reg <= GLYPH_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ROW_COUNT:   row_count_reg   <= cfg_data[ROW_CFG_W-1:0];
                CFG_COL_COUNT:   col_count_reg   <= cfg_data[COL_CFG_W-1:0];
                CFG_GLYPH_COUNT: glyph_count_reg <= cfg_data[GLYPH_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (32'(glyph_count_reg) > MAX_GLYPHS)
            glyph_limit = GLYPH_CNT_W'(MAX_GLYPHS);
        else
            glyph_limit = GLYPH_CNT_W'(glyph_count_reg);

        if (row_count_reg == '0)
            rows_eff = ROW_CNT_W'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows_eff = ROW_CNT_W'(MAX_ROWS);
        else
            rows_eff = ROW_CNT_W'(row_count_reg);

        if (col_count_reg == '0)
            cols_eff = COL_CFG_W'(1);
        else if (32'(col_count_reg) > MAX_COLS)
            cols_eff = COL_CFG_W'(MAX_COLS);
        else
            cols_eff = col_count_reg;

        for (int b = 0; b < WORD_BYTES; b++)
        begin
            byte_mask[b*8 +: 8] = (32'(cols_eff) > b) ? 8'hFF : 8'h00;
        end
    end

    assign bound_sum   = {1'b0, low_reg} + {1'b0, high_reg};
    assign mid_next    = GLYPH_IDX_W'(bound_sum[GLYPH_CNT_W:1]);
    assign key_below   = key_reg < code_rd_reg;
    assign bmp_rd_addr = BMP_ADDR_W'(BMP_ADDR_W'(mid_reg) * BMP_ADDR_W'(MAX_ROWS)
                                     + BMP_ADDR_W'(row_reg));

    // Code table: one write port for load items, one registered read for probes.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_code && (32'(entry_index) < MAX_GLYPHS))
        begin
            code_mem[GLYPH_IDX_W'(entry_index)] <= code_value;
        end
        if (cmd.probe)
        begin
            code_rd_reg <= code_mem[mid_next];
        end
    end

    // Bitmap store: one write port for load items, one registered read for rows.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_row && (32'(entry_index) < BMP_DEPTH))
        begin
            bitmap_mem[BMP_ADDR_W'(entry_index)] <= row_word;
        end
        if (cmd.row_read)
        begin
            bmp_rd_reg <= bitmap_mem[bmp_rd_addr];
        end
    end

    // Search bounds and row counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            high_reg <= '0;
            mid_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                low_reg  <= '0;
                high_reg <= glyph_limit;
                row_reg  <= '0;
            end
            if (cmd.probe)
            begin
                mid_reg <= mid_next;
            end
            if (cmd.compare && !status.hit)
            begin
                if (key_below)
                    high_reg <= GLYPH_CNT_W'(mid_reg);
                else
                    low_reg <= GLYPH_CNT_W'(mid_reg) + GLYPH_CNT_W'(1);
            end
            if (cmd.load_row)
            begin
                row_reg <= row_reg + ROW_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_reg <= code_value;
        end
    end

    // Output register: a loaded item waits here while the controller moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_row || cmd.load_miss)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_row)
        begin
            pixels_reg     <= bmp_rd_reg & byte_mask;
            row_number_reg <= ROWNUM_W'(row_reg);
            found_reg      <= 1'b1;
            last_reg       <= status.row_last;
        end
        else if (cmd.load_miss)
        begin
            pixels_reg     <= '0;
            row_number_reg <= '0;
            found_reg      <= 1'b0;
            last_reg       <= 1'b1;
        end
    end

    always_comb
    begin
        status.bounds_empty = !(low_reg < high_reg);
        status.hit          = (code_rd_reg == key_reg);
        status.row_last     = (ROW_CNT_W'(row_reg) + ROW_CNT_W'(1)) == rows_eff;
        status.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign row_pixels = pixels_reg;
    assign row_number = row_number_reg;
    assign found      = found_reg;
    assign last_row   = last_reg;

endmodule

`default_nettype wire

// File: hdl/glyph_lookup_engine_core.sv
// Top level of the glyph lookup engine: controller, datapath and checks.
//
// Load items (code entry or bitmap row word) are taken in the idle state and
// give no result; an unused opcode is dropped the same way. A lookup item
// keeps the block busy for its search probes (each a registered read of the
// code table followed by the compare), at most ceil(log2(glyph_count+1))
// probes, i.e. 9 for a full table of 256 codes. A miss then gives one item;
// a hit gives one item per row (row_count, taken as 1..32), each a bitmap
// store read, then an output register load; stalls on the output hold these
// loads. The output register lets the next input item be taken while the
// final result still waits. Configuration registers are written with no
// handshake and must only change while the block is idle. Memories are not
// cleared at reset.
`default_nettype none

`include "assert_macros.svh"

module glyph_lookup_engine_core
    import gle_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [OPCODE_W-1:0]      opcode,
    input  wire logic [ENTRY_W-1:0]       entry_index,
    input  wire logic signed [CODE_W-1:0] code_value,
    input  wire logic [WORD_W-1:0]        row_word,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [WORD_W-1:0]             row_pixels,
    output logic [ROWNUM_W-1:0]           row_number,
    output logic                          found,
    output logic                          last_row
);

    gle_cmd_t    cmd;
    gle_status_t status;
    logic        result_load;

    gle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    gle_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .entry_index (entry_index),
        .code_value  (code_value),
        .row_word    (row_word),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_pixels  (row_pixels),
        .row_number  (row_number),
        .found       (found),
        .last_row    (last_row)
    );

    assign result_load = cmd.load_row || cmd.load_miss;

    // A result is only loaded when the previous one is gone or leaving.
    `ASSERT_CLK(a_load_has_room, result_load |-> status.out_free, "output item overwritten")

    // A lookup start takes the block out of the idle state, so in_ready must fall.
    `ASSERT_CLK(a_busy_after_start, cmd.start |=> !in_ready, "item accepted during lookup")

    // A miss result is always the final one of its lookup.
    `ASSERT_NEVER(a_miss_is_last, out_valid && !found && !last_row, "miss item not marked last")

endmodule

`default_nettype wire

// File: tb/tb_glyph_lookup_engine_core.sv
// Self-checking testbench for the glyph lookup engine core: code tables, bitmap rows, lookups.
module tb_glyph_lookup_engine_core;
    import gle_pkg::*;

    localparam logic [OPCODE_W-1:0]      OP_UNUSED     = 2'd3;
    localparam int                       CYCLE_LIMIT   = 1000000;
    localparam int                       SETTLE_CYCLES = 64;
    localparam int                       MAX_REPORTS   = 40;
    localparam logic signed [CODE_W-1:0] CODE_MIN      = 32'sh8000_0000;
    localparam logic signed [CODE_W-1:0] CODE_MAX      = 32'sh7fff_ffff;

    typedef struct packed {
        logic [WORD_W-1:0]   pixels;
        logic [ROWNUM_W-1:0] row;
        logic                found;
        logic                last;
    } glyph_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [OPCODE_W-1:0]      opcode = '0;
    logic [ENTRY_W-1:0]       entry_index = '0;
    logic signed [CODE_W-1:0] code_value = '0;
    logic [WORD_W-1:0]        row_word = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [WORD_W-1:0]        row_pixels;
    logic [ROWNUM_W-1:0]      row_number;
    logic                     found;
    logic                     last_row;

    // Shadow copy of the block's tables and registers.
    logic signed [CODE_W-1:0] code_tbl [MAX_GLYPHS];
    logic [WORD_W-1:0]        bmp_tbl [BMP_DEPTH];
    bit                       bmp_wr [BMP_DEPTH];
    logic [ROW_CFG_W-1:0]     row_cfg = ROW_COUNT_RST;
    logic [COL_CFG_W-1:0]     col_cfg = COL_COUNT_RST;
    logic [GLYPH_CFG_W-1:0]   glyph_cfg = GLYPH_COUNT_RST;

    glyph_row_t rows_due [$];
    int         fail_count = 0;
    int         cycle_count = 0;
    int         idle_pct = 14;
    int         hold_cycles_req = 0;

    glyph_lookup_engine_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .entry_index (entry_index),
        .code_value  (code_value),
        .row_word    (row_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_pixels  (row_pixels),
        .row_number  (row_number),
        .found       (found),
        .last_row    (last_row)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int search_limit();
        return (glyph_cfg > MAX_GLYPHS) ? MAX_GLYPHS : int'(glyph_cfg);
    endfunction

    function automatic int glyph_rows();
        if (row_cfg == 0)
            return 1;
        return (row_cfg > MAX_ROWS) ? MAX_ROWS : int'(row_cfg);
    endfunction

    function automatic bit find_slot(input logic signed [CODE_W-1:0] key, output int slot);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = search_limit();
        slot = 0;
        while (lo < hi)
        begin
            mid = (lo + hi) >> 1;
            if (code_tbl[mid] == key)
            begin
                slot = mid;
                return 1'b1;
            end
            if (key < code_tbl[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // Updates the shadow tables for one accepted item and queues the rows it yields.
    function automatic void predict_rows(input logic [OPCODE_W-1:0] op,
                                         input logic [ENTRY_W-1:0] idx,
                                         input logic signed [CODE_W-1:0] key,
                                         input logic [WORD_W-1:0] word);
        int               slot;
        int               rows;
        int               cols;
        logic [WORD_W-1:0] mask;
        glyph_row_t       res;
        case (op)
            OP_WR_CODE:
            begin
                if (idx < MAX_GLYPHS)
                begin
                    code_tbl[idx] = key;
                end
            end
            OP_WR_ROW:
            begin
                if (idx < BMP_DEPTH)
                begin
                    bmp_tbl[idx] = word;
                    bmp_wr[idx] = 1'b1;
                end
            end
            OP_LOOKUP:
            begin
                if (!find_slot(key, slot))
                begin
                    res = '{pixels: '0, row: '0, found: 1'b0, last: 1'b1};
                    rows_due.push_back(res);
                end
                else
                begin
                    rows = glyph_rows();
                    cols = (col_cfg == 0) ? 1 : ((col_cfg > MAX_COLS) ? MAX_COLS : int'(col_cfg));
                    mask = (cols >= WORD_BYTES) ? '1 : ((64'd1 << (cols * 8)) - 64'd1);
                    for (int r = 0; r < rows; r++)
                    begin
                        res.pixels = bmp_tbl[slot * MAX_ROWS + r] & mask;
                        res.row = ROWNUM_W'(r);
                        res.found = 1'b1;
                        res.last = (r == rows - 1);
                        rows_due.push_back(res);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [ENTRY_W-1:0] idx,
                             input logic signed [CODE_W-1:0] key, input logic [WORD_W-1:0] word);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        entry_index <= idx;
        code_value <= key;
        row_word <= word;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        predict_rows(op, idx, key, word);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        // Load items give no result, so let any that are still in flight drain.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (sel)
            CFG_ROW_COUNT:   row_cfg = val[ROW_CFG_W-1:0];
            CFG_COL_COUNT:   col_cfg = val[COL_CFG_W-1:0];
            CFG_GLYPH_COUNT: glyph_cfg = val[GLYPH_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // Writes any bitmap rows a hit would read that are still unwritten, then looks the code up.
    task automatic look_up_glyph(input logic signed [CODE_W-1:0] key);
        int slot;
        int rows;
        rows = glyph_rows();
        if (find_slot(key, slot))
        begin
            for (int r = 0; r < rows; r++)
            begin
                if (!bmp_wr[slot * MAX_ROWS + r])
                    push_item(OP_WR_ROW, ENTRY_W'(slot * MAX_ROWS + r), $urandom,
                              {$urandom, $urandom});
            end
        end
        push_item(OP_LOOKUP, ENTRY_W'($urandom), key, {$urandom, $urandom});
    endtask

    // Fills slots 0..n-1 with ascending codes, either tightly packed or spread out.
    task automatic load_table(input int n, input bit dense);
        longint span;
        longint room;
        longint cur;
        span = dense ? 64'd4 : 64'd4294967295 / (n + 1);
        room = 64'd4294967295 - span * (n + 1);
        cur = longint'(CODE_MIN) + (longint'($urandom) % (room + 1))
              + (longint'($urandom) % span);
        for (int j = 0; j < n; j++)
        begin
            push_item(OP_WR_CODE, ENTRY_W'(j), cur[CODE_W-1:0], {$urandom, $urandom});
            cur = cur + 1 + (longint'($urandom) % span);
        end
    endtask

    task automatic random_item(output bit counted);
        int                       lim;
        int                       pick;
        int                       j;
        logic signed [CODE_W-1:0] key;
        lim = search_limit();
        pick = $urandom_range(0, 99);
        counted = 1'b1;
        if (pick < 70)
        begin
            if (lim == 0 || pick >= 55)
                key = $urandom;
            else
            begin
                j = $urandom_range(0, lim - 1);
                key = code_tbl[j];
                // Neighbors of stored codes mostly miss after a full descent.
                if (pick >= 45)
                    key = ($urandom_range(0, 1) == 1) ? key + 1 : key - 1;
            end
            look_up_glyph(key);
        end
        else if (pick < 80)
            push_item(OP_WR_ROW, ENTRY_W'($urandom), $urandom, {$urandom, $urandom});
        else if (pick < 88)
        begin
            push_item(OP_WR_CODE, ENTRY_W'($urandom_range(MAX_GLYPHS, 8191)), $urandom,
                      {$urandom, $urandom});
            counted = 1'b0;
        end
        else if (pick < 92)
            push_item(OP_WR_CODE, ENTRY_W'($urandom_range(0, MAX_GLYPHS - 1)), $urandom,
                      {$urandom, $urandom});
        else
        begin
            push_item(OP_UNUSED, ENTRY_W'($urandom), $urandom, {$urandom, $urandom});
            counted = 1'b0;
        end
    endtask

    task automatic run_items(input int n);
        int done;
        bit counted;
        done = 0;
        while (done < n)
        begin
            random_item(counted);
            done += counted;
        end
    endtask

    task automatic test_empty_table();
        look_up_glyph('0);
        look_up_glyph(CODE_MIN);
        look_up_glyph(CODE_MAX);
        push_item(OP_UNUSED, '1, '1, '1);
        push_item(OP_WR_CODE, '1, 32'sh1234_5678, '0);
        push_item(OP_WR_ROW, '1, '0, '1);
        look_up_glyph(32'sh1234_5678);
    endtask

    task automatic test_small_table();
        push_item(OP_WR_CODE, 13'd0, CODE_MIN, '0);
        push_item(OP_WR_CODE, 13'd1, -32'sd1, '1);
        push_item(OP_WR_CODE, 13'd2, 32'sd0, '0);
        push_item(OP_WR_CODE, 13'd3, CODE_MAX, '1);
        set_reg(CFG_ROW_COUNT, 9'd2);
        set_reg(CFG_GLYPH_COUNT, 9'd4);
        look_up_glyph(CODE_MIN);
        look_up_glyph(-32'sd1);
        look_up_glyph(32'sd0);
        look_up_glyph(CODE_MAX);
        look_up_glyph(32'sd1);
        look_up_glyph(CODE_MAX - 1);
        // A code write past the table end must leave the table alone.
        push_item(OP_WR_CODE, 13'd256, 32'sd1, '0);
        look_up_glyph(32'sd1);
        set_reg(CFG_COL_COUNT, 9'd0);
        look_up_glyph(-32'sd1);
        set_reg(CFG_COL_COUNT, 9'd15);
        look_up_glyph(-32'sd1);
        set_reg(CFG_COL_COUNT, 9'd3);
        look_up_glyph(32'sd0);
        set_reg(CFG_ROW_COUNT, 9'd0);
        look_up_glyph(32'sd0);
        set_reg(CFG_ROW_COUNT, 9'd63);
        look_up_glyph(CODE_MAX);
        set_reg(CFG_ROW_COUNT, 9'd32);
        look_up_glyph(CODE_MAX);
        set_reg(CFG_GLYPH_COUNT, 9'd1);
        look_up_glyph(CODE_MAX);
        look_up_glyph(CODE_MIN);
    endtask

    task automatic test_random_traffic();
        int n;
        for (int p = 0; p < 2; p++)
        begin
            n = (p == 0) ? 1 : $urandom_range(2, 16);
            load_table(n, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 3) == 0)
                set_reg(CFG_GLYPH_COUNT, CFG_DATA_W'($urandom_range(0, n)));
            else
                set_reg(CFG_GLYPH_COUNT, CFG_DATA_W'(n));
            if ($urandom_range(0, 3) == 0)
                set_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(0, 63)));
            else
                set_reg(CFG_ROW_COUNT, CFG_DATA_W'($urandom_range(1, 8)));
            set_reg(CFG_COL_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
            run_items(15);
        end
    endtask

    task automatic test_full_table();
        load_table(MAX_GLYPHS, 1'($urandom_range(0, 1)));
        push_item(OP_WR_CODE, 13'd0, CODE_MIN, {$urandom, $urandom});
        push_item(OP_WR_CODE, 13'd255, CODE_MAX, {$urandom, $urandom});
        set_reg(CFG_ROW_COUNT, 9'd2);
        set_reg(CFG_COL_COUNT, 9'd8);
        set_reg(CFG_GLYPH_COUNT, 9'd256);
        look_up_glyph(CODE_MIN);
        look_up_glyph(CODE_MAX);
        run_items(6);
        // Counts above the table size saturate to a full table.
        set_reg(CFG_GLYPH_COUNT, 9'd511);
        look_up_glyph(CODE_MAX);
        set_reg(CFG_GLYPH_COUNT, 9'd255);
        look_up_glyph(CODE_MAX);
    endtask

    task automatic test_output_stall();
        set_reg(CFG_ROW_COUNT, 9'd4);
        hold_cycles_req = 400;
        run_items(12);
    endtask

    task automatic test_no_idle();
        set_reg(CFG_ROW_COUNT, 9'd1);
        idle_pct = 0;
        run_items(15);
        idle_pct = 14;
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endtask

    // Result side: random stalls, plus one long hold-off when a test asks for it.
    initial
    begin
        int hold;
        forever
        begin
            @(negedge clk);
            if (hold_cycles_req > 0)
            begin
                hold = hold_cycles_req;
                hold_cycles_req = 0;
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_rows
        glyph_row_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (rows_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result, row_pixels %h row_number %0d",
                             $time, row_pixels, row_number,
                             " found %b last %b", found, last_row);
            end
            else
            begin
                want = rows_due.pop_front();
                if (row_pixels !== want.pixels)
                    report_mismatch("row_pixels", want.pixels, row_pixels);
                if (row_number !== want.row)
                    report_mismatch("row_number", want.row, row_number);
                if (found !== want.found)
                    report_mismatch("found", want.found, found);
                if (last_row !== want.last)
                    report_mismatch("last_row", want.last, last_row);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, rows_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_small_table();
        test_random_traffic();
        test_full_table();
        test_output_stall();
        test_no_idle();
        wait_idle();
        if (fail_count == 0 && rows_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: glyph_lookup_engine_core.f
+incdir+hdl
hdl/gle_pkg.sv
hdl/gle_ctrl.sv
hdl/gle_datapath.sv
hdl/glyph_lookup_engine_core.sv
tb/tb_glyph_lookup_engine_core.sv
